### hw/rtl/echt_pkg.sv
// Shared constants and types for the evaluation correction history tables.
// Field layout of the stream beats, blend weights, update gains, default parameters.
// No dependencies.
package echt_pkg;

  localparam int unsigned DEF_TABLE_ENTRIES = 4096;
  localparam int unsigned DEF_ENTRY_LIMIT   = 16384;
  localparam int unsigned DEF_EVAL_SCALE    = 256;
  localparam int unsigned DEF_MATE_BOUND    = 31000;

  localparam int unsigned NUM_TABLES = 4;
  localparam int unsigned TBL_PAWN   = 0;
  localparam int unsigned TBL_MINOR  = 1;
  localparam int unsigned TBL_WMAT   = 2;
  localparam int unsigned TBL_BMAT   = 3;

  localparam int unsigned IDX_W   = 12;
  localparam int unsigned ENTRY_W = 16;
  localparam int unsigned EVAL_W  = 16;
  localparam int unsigned DEPTH_W = 7;
  localparam int unsigned ERR_W   = 16;

  // input tdata layout, lowest bit first
  localparam int unsigned OFF_SIDE  = 0;
  localparam int unsigned OFF_PAWN  = 1;
  localparam int unsigned OFF_MINOR = 13;
  localparam int unsigned OFF_WMAT  = 25;
  localparam int unsigned OFF_BMAT  = 37;
  localparam int unsigned OFF_RAW   = 49;
  localparam int unsigned OFF_DEPTH = 65;
  localparam int unsigned OFF_ERR   = 72;
  localparam int unsigned IN_DATA_W  = 88;
  localparam int unsigned OUT_DATA_W = 16;

  localparam int unsigned BLEND_PAWN     = 128;
  localparam int unsigned BLEND_MINOR    = 88;
  localparam int unsigned BLEND_MATERIAL = 108;
  localparam int unsigned BLEND_UNIT     = 128;

  localparam int unsigned GAIN_PAWN     = 128;
  localparam int unsigned GAIN_MINOR    = 150;
  localparam int unsigned GAIN_MATERIAL = 186;
  localparam int unsigned GAIN_W        = 8;
  localparam int unsigned GAIN_SHIFT    = 7;
  localparam int unsigned BONUS_SHIFT   = 3;

  localparam int unsigned TABLE_GAIN [NUM_TABLES] =
    '{GAIN_PAWN, GAIN_MINOR, GAIN_MATERIAL, GAIN_MATERIAL};

  typedef enum logic {
    OP_QUERY  = 1'b0,
    OP_UPDATE = 1'b1
  } op_t;

endpackage

### hw/rtl/eval_correction_history_tables_unit.sv
// Evaluation correction history tables: four signed 16-bit tables (pawn, minor, white and
// black non-pawn material), each split by side to move, in four single-port-write memories.
// Query beats (tuser 0) return raw_eval plus the blended correction, clamped below the mate
// bound; update beats (tuser 1) apply a gravity update to the four addressed entries and
// return nothing. One item is in flight at a time: each passes through index reduction,
// memory read, blend or gain and two reciprocal multiplies, and an update then writes back,
// before the next is accepted; a query also waits while the output register is full.
// After reset a clearing pass zeroes all 2*TABLE_ENTRIES words of each memory before the
// first beat is taken. A finished result sits in the output register and the next item can
// be taken while it waits.
// Depends on echt_pkg.
module eval_correction_history_tables_unit #(
  parameter int unsigned TABLE_ENTRIES = echt_pkg::DEF_TABLE_ENTRIES,
  parameter int unsigned ENTRY_LIMIT   = echt_pkg::DEF_ENTRY_LIMIT,
  parameter int unsigned EVAL_SCALE    = echt_pkg::DEF_EVAL_SCALE,
  parameter int unsigned MATE_BOUND    = echt_pkg::DEF_MATE_BOUND
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // side, pawn_index, minor_index, white_material_index, black_material_index,
  // raw_eval, search_depth, eval_error
  input  logic [echt_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                             s_axis_tuser,   // operation
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [echt_pkg::OUT_DATA_W-1:0] m_axis_tdata     // corrected_eval
);
  import echt_pkg::*;

  localparam int unsigned ADDR_W = $clog2(2 * TABLE_ENTRIES);

  // index mod TABLE_ENTRIES: quotient by reciprocal, exact for 12-bit indexes
  localparam int unsigned IDX_SH = IDX_W + $clog2(TABLE_ENTRIES);
  localparam longint unsigned IDX_M =
    ((64'd1 << IDX_SH) + TABLE_ENTRIES - 1) / TABLE_ENTRIES;
  localparam int unsigned IDX_PW = IDX_SH + IDX_W;

  localparam int unsigned DMAG_W = ERR_W + DEPTH_W;
  localparam int unsigned BON_W  = DMAG_W - BONUS_SHIFT;
  localparam int unsigned SC_W   = BON_W + GAIN_W;
  localparam int unsigned SCS_W  = SC_W - GAIN_SHIFT;

  localparam int unsigned LIM_Q  = ENTRY_LIMIT / 4;
  localparam int unsigned MAG_W  = $clog2(LIM_Q + 1);
  localparam int unsigned PROD_W = ENTRY_W + MAG_W;
  localparam int unsigned LIM_SH = PROD_W + $clog2(ENTRY_LIMIT);
  localparam longint unsigned LIM_M =
    ((64'd1 << LIM_SH) + ENTRY_LIMIT - 1) / ENTRY_LIMIT;
  localparam int unsigned LIM_PW = LIM_SH + MAG_W;
  localparam int unsigned UPD_W  = ENTRY_W + 2;

  // blended sum stays below 2^24 in magnitude
  localparam int unsigned TOT_W  = 25;
  localparam int unsigned TOTS_W = TOT_W + 1;
  localparam int unsigned DIV_D  = EVAL_SCALE * BLEND_UNIT;
  localparam int unsigned DIV_SH = TOT_W + $clog2(DIV_D);
  localparam longint unsigned DIV_M = ((64'd1 << DIV_SH) + DIV_D - 1) / DIV_D;
  localparam int unsigned QT_W   = TOT_W - $clog2(BLEND_UNIT);
  localparam int unsigned DIV_PW = DIV_SH + QT_W;
  localparam int unsigned ADJ_W  = QT_W + 2;

  localparam logic signed [TOTS_W-1:0] W_PAWN  = TOTS_W'(BLEND_PAWN);
  localparam logic signed [TOTS_W-1:0] W_MINOR = TOTS_W'(BLEND_MINOR);
  localparam logic signed [TOTS_W-1:0] W_MAT   = TOTS_W'(BLEND_MATERIAL);
  localparam logic signed [ADJ_W-1:0]  ADJ_MAX = ADJ_W'(MATE_BOUND - 1);
  localparam logic signed [ADJ_W-1:0]  ADJ_MIN = -ADJ_MAX;
  localparam logic signed [UPD_W-1:0]  LIM_P   = UPD_W'(ENTRY_LIMIT);
  localparam logic signed [UPD_W-1:0]  LIM_N   = -LIM_P;

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_ADDR  = 7'b0000100,
    ST_BLEND = 7'b0001000,
    ST_SCALE = 7'b0010000,
    ST_DIV   = 7'b0100000,
    ST_WRITE = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic [ADDR_W-1:0] clr_addr;

  logic accept;
  logic out_load;

  op_t                      op;
  logic                     side;
  logic signed [EVAL_W-1:0] raw_eval;
  logic                     err_neg;
  logic [DMAG_W-1:0]        dmag;

  logic [ERR_W-1:0]          in_err;
  logic [ERR_W-1:0]          in_err_mag;
  logic [IDX_W-1:0]          idx_in [NUM_TABLES];
  logic signed [ENTRY_W-1:0] rd_data [NUM_TABLES];

  logic signed [TOTS_W-1:0] tot;
  logic                     tot_neg;
  logic [TOT_W-1:0]         tot_mag;
  logic [DIV_PW-1:0]        div_prod;
  logic [QT_W-1:0]          corr;
  logic signed [ADJ_W-1:0]  adj;

  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state == ST_DIV) && (op == OP_QUERY) &&
                         (!m_axis_tvalid || m_axis_tready);

  assign in_err     = s_axis_tdata[OFF_ERR +: ERR_W];
  assign in_err_mag = in_err[ERR_W-1] ? (~in_err + ERR_W'(1)) : in_err;
  assign idx_in[TBL_PAWN]  = s_axis_tdata[OFF_PAWN +: IDX_W];
  assign idx_in[TBL_MINOR] = s_axis_tdata[OFF_MINOR +: IDX_W];
  assign idx_in[TBL_WMAT]  = s_axis_tdata[OFF_WMAT +: IDX_W];
  assign idx_in[TBL_BMAT]  = s_axis_tdata[OFF_BMAT +: IDX_W];

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == ADDR_W'(2 * TABLE_ENTRIES - 1)) state_next = ST_IDLE;
      end
      ST_IDLE:  if (s_axis_tvalid) state_next = ST_ADDR;
      ST_ADDR:  state_next = ST_BLEND;
      ST_BLEND: state_next = ST_SCALE;
      ST_SCALE: state_next = ST_DIV;
      ST_DIV: begin
        if (op == OP_UPDATE) state_next = ST_WRITE;
        else if (!m_axis_tvalid || m_axis_tready) state_next = ST_IDLE;
      end
      ST_WRITE: state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      clr_addr      <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_addr <= clr_addr + ADDR_W'(1);
      if (out_load) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
    end
  end

  // item capture; the bonus magnitude |err|*depth is formed on the way in
  always_ff @(posedge clk) begin
    if (accept) begin
      op       <= op_t'(s_axis_tuser);
      side     <= s_axis_tdata[OFF_SIDE];
      raw_eval <= s_axis_tdata[OFF_RAW +: EVAL_W];
      err_neg  <= in_err[ERR_W-1];
      dmag     <= DMAG_W'(in_err_mag) * DMAG_W'(s_axis_tdata[OFF_DEPTH +: DEPTH_W]);
    end
  end

  // query path: blend, reciprocal divide, add and clamp
  assign tot = TOTS_W'(rd_data[TBL_PAWN]) * W_PAWN +
               TOTS_W'(rd_data[TBL_MINOR]) * W_MINOR +
               (TOTS_W'(rd_data[TBL_WMAT]) + TOTS_W'(rd_data[TBL_BMAT])) * W_MAT;
  assign div_prod = DIV_PW'(tot_mag) * DIV_PW'(DIV_M);
  assign adj = ADJ_W'(raw_eval) +
               (tot_neg ? -$signed(ADJ_W'(corr)) : $signed(ADJ_W'(corr)));

  always_ff @(posedge clk) begin
    if (state == ST_BLEND) begin
      tot_neg <= tot[TOTS_W-1];
      tot_mag <= tot[TOTS_W-1] ? TOT_W'(-tot) : TOT_W'(tot);
    end
    if (state == ST_SCALE) corr <= div_prod[DIV_SH +: QT_W];
    if (out_load) begin
      if (adj > ADJ_MAX)      m_axis_tdata <= OUT_DATA_W'(ADJ_MAX);
      else if (adj < ADJ_MIN) m_axis_tdata <= OUT_DATA_W'(ADJ_MIN);
      else                    m_axis_tdata <= OUT_DATA_W'(adj);
    end
  end

  // one memory and one update lane per table
  for (genvar k = 0; k < NUM_TABLES; k++) begin : g_tbl
    logic signed [ENTRY_W-1:0] mem [2 * TABLE_ENTRIES];
    logic signed [ENTRY_W-1:0] rd_q;
    logic [IDX_PW-1:0]         idx_prod;
    logic [IDX_W-1:0]          idx_x, idx_q, idx_red;
    logic [ADDR_W-1:0]         addr_calc, addr;
    logic [ENTRY_W-1:0]        e_mag;
    logic [SC_W-1:0]           scaled;
    logic [SCS_W-1:0]          sc_sh;
    logic [MAG_W-1:0]          bmag_next, bmag, grav;
    logic [PROD_W-1:0]         prod;
    logic [LIM_PW-1:0]         lim_prod;
    logic signed [UPD_W-1:0]   bterm, gterm, upd;
    logic signed [ENTRY_W-1:0] wr_data;
    logic                      mem_we;
    logic [ADDR_W-1:0]         mem_wa;
    logic signed [ENTRY_W-1:0] mem_wd;

    assign idx_prod  = IDX_PW'(idx_in[k]) * IDX_PW'(IDX_M);
    assign idx_red   = idx_x - IDX_W'(32'(idx_q) * 32'(TABLE_ENTRIES));
    assign addr_calc = ADDR_W'(idx_red) + (side ? ADDR_W'(TABLE_ENTRIES) : '0);

    assign e_mag     = rd_q[ENTRY_W-1] ? ENTRY_W'(-rd_q) : ENTRY_W'(rd_q);
    assign sc_sh     = scaled[SC_W-1:GAIN_SHIFT];
    assign bmag_next = (sc_sh > SCS_W'(LIM_Q)) ? MAG_W'(LIM_Q) : MAG_W'(sc_sh);
    assign lim_prod  = LIM_PW'(prod) * LIM_PW'(LIM_M);

    // gravity: e + bonus - sign(e)*(|e|*|bonus|/LIMIT)
    assign bterm = err_neg ? -$signed(UPD_W'(bmag)) : $signed(UPD_W'(bmag));
    assign gterm = rd_q[ENTRY_W-1] ? -$signed(UPD_W'(grav)) : $signed(UPD_W'(grav));
    assign upd   = UPD_W'(rd_q) + bterm - gterm;

    always_comb begin
      if (upd > LIM_P)      wr_data = ENTRY_W'(LIM_P);
      else if (upd < LIM_N) wr_data = ENTRY_W'(LIM_N);
      else                  wr_data = ENTRY_W'(upd);
    end

    assign mem_we = (state == ST_CLEAR) || (state == ST_WRITE);
    assign mem_wa = (state == ST_CLEAR) ? clr_addr : addr;
    assign mem_wd = (state == ST_CLEAR) ? '0 : wr_data;

    always_ff @(posedge clk) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      if (state == ST_ADDR) rd_q <= mem[addr_calc];
    end

    always_ff @(posedge clk) begin
      if (accept) begin
        idx_x <= idx_in[k];
        idx_q <= idx_prod[IDX_SH +: IDX_W];
      end
      if (state == ST_ADDR)  addr <= addr_calc;
      if (state == ST_BLEND) scaled <= SC_W'(dmag[DMAG_W-1:BONUS_SHIFT]) * SC_W'(TABLE_GAIN[k]);
      if (state == ST_SCALE) begin
        bmag <= bmag_next;
        prod <= PROD_W'(e_mag) * PROD_W'(bmag_next);
      end
      if (state == ST_DIV) grav <= lim_prod[LIM_SH +: MAG_W];
    end

    assign rd_data[k] = rd_q;
  end

endmodule

### hw/rtl/echt_chk.sv
// Port-level checks for the evaluation correction history tables unit.
// Bound to the top level below; depends on echt_pkg.
module echt_chk #(
  parameter int unsigned MATE_BOUND = echt_pkg::DEF_MATE_BOUND
) (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [echt_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import echt_pkg::*;

  localparam logic signed [EVAL_W-1:0] EVAL_MAX = EVAL_W'(MATE_BOUND - 1);

  // a stalled result beat stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat dropped or changed while stalled");

  a_out_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ($signed(m_axis_tdata) <= EVAL_MAX) &&
                      ($signed(m_axis_tdata) >= -EVAL_MAX))
    else $error("corrected_eval outside mate bound");

  // one item in flight: ready drops right after a beat is taken
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second item taken while one is in flight");

  // no result can appear the cycle after an accept
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
    else $error("result beat appeared too early");

endmodule

bind eval_correction_history_tables_unit echt_chk #(.MATE_BOUND(MATE_BOUND)) u_echt_chk (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
